// ----- src/lrup_pkg.sv -----
package lrup_pkg;

  localparam int FRAMES_DEF    = 4;
  localparam int PAGE_BITS_DEF = 16;

  localparam int FIDX_W  = 2;
  localparam int FAULT_W = 16;
  localparam int CFG_W   = 3;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 3'd4;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic [0:0] {
    REG_FRAMES_IN_USE = 1'b0
  } lrup_reg_e;

  // running lookup state along the cell row
  typedef struct packed {
    logic hit_seen;
    logic lru_seen;
  } lrup_scan_t;

  typedef struct packed {
    logic en;
    logic hit;
    logic fill;
  } lrup_upd_t;

endpackage

// ----- src/lrup_in_if.sv -----
interface lrup_in_if
  import lrup_pkg::*;
#(
  parameter int PAGE_BITS = PAGE_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

// ----- src/lrup_out_if.sv -----
interface lrup_out_if
  import lrup_pkg::*;
#(
  parameter int PAGE_BITS = PAGE_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [FIDX_W-1:0]    frame_index;
  logic                 evicted_valid;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [FAULT_W-1:0]   fault_count;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_count, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_count, output ready);
endinterface

// ----- src/lrup_cfg.sv -----
module lrup_cfg
  import lrup_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [CFG_W-1:0]  frames_in_use_o
);

  logic [CFG_W-1:0] frames_in_use_q, frames_in_use_d;
  lrup_reg_e        reg_sel;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_sel = lrup_reg_e'(paddr[APB_AW-1]);
  assign wr_en   = psel && penable && pwrite && pready && (paddr[APB_AW-2:0] == '0);

  always_comb begin
    frames_in_use_d = frames_in_use_q;
    prdata          = '0;
    unique case (reg_sel)
      REG_FRAMES_IN_USE: begin
        prdata = APB_DW'(frames_in_use_q);
        if (wr_en) begin
          frames_in_use_d = pwdata[CFG_W-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= FRAMES_IN_USE_RST;
    end else begin
      frames_in_use_q <= frames_in_use_d;
    end
  end

  assign frames_in_use_o = frames_in_use_q;

endmodule

// ----- src/lrup_cell.sv -----
module lrup_cell
  import lrup_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  parameter int IDX       = 0,
  localparam int RW       = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int CNT_W    = $clog2(FRAMES + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lrup_scan_t           scan_i,
  output lrup_scan_t           scan_o,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic [RW-1:0]        last_rank_i,
  input  logic [RW-1:0]        hit_rank_i,
  input  logic [CNT_W-1:0]     filled_i,
  input  lrup_upd_t            upd_i,
  output logic                 hit_o,
  output logic                 sel_o,
  output logic [RW-1:0]        rank_o,
  output logic [PAGE_BITS-1:0] page_o
);

  logic                 valid_q, valid_d;
  logic [RW-1:0]        rank_q, rank_d;
  logic [PAGE_BITS-1:0] page_q;
  logic                 hit_here, lru_here, fill_here;

  assign hit_here  = valid_q && (page_q == page_i) && !scan_i.hit_seen;
  assign lru_here  = valid_q && (rank_q == last_rank_i) && !scan_i.lru_seen;
  assign fill_here = (filled_i == CNT_W'(IDX));

  assign scan_o.hit_seen = scan_i.hit_seen || hit_here;
  assign scan_o.lru_seen = scan_i.lru_seen || lru_here;

  assign sel_o  = upd_i.hit ? hit_here : (upd_i.fill ? fill_here : lru_here);
  assign hit_o  = hit_here;
  assign rank_o = rank_q;
  assign page_o = page_q;

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    if (upd_i.en) begin
      if (sel_o) begin
        valid_d = 1'b1;
        rank_d  = '0;
      end else if (valid_q && (!upd_i.hit || (rank_q < hit_rank_i))) begin
        rank_d = rank_q + RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.en && sel_o && !upd_i.hit) begin
      page_q <= page_i;
    end
  end

endmodule

// ----- src/lru_page_replacement.sv -----
// LRU page replacement over FRAMES fully associative frames. One access word is taken per
// clock cycle: every frame cell compares its page and its recency rank in the same cycle, the
// row of cells resolves the first hit and the least recent frame, and the result word is
// registered, so it appears in the cycle after the access is accepted. The input stalls only
// while a finished result is held by the output side. frames_in_use limits how many frames
// are filled before replacement starts; write it only while no access is in flight.
module lru_page_replacement
  import lrup_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lrup_in_if.sink           in_i,
  lrup_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int RW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]     frames_in_use;
  lrup_scan_t           scan [FRAMES+1];
  logic [FRAMES-1:0]    hit_vec, sel_vec;
  logic [RW-1:0]        rank_vec [FRAMES];
  logic [PAGE_BITS-1:0] page_vec [FRAMES];

  logic [CNT_W-1:0]     filled_q, filled_d;
  logic [FAULT_W-1:0]   fault_q, fault_d;
  logic                 out_valid_q;
  logic                 out_hit_q;
  logic [FIDX_W-1:0]    out_frame_q;
  logic                 out_ev_valid_q;
  logic [PAGE_BITS-1:0] out_ev_page_q;

  logic                 accept;
  logic                 is_hit, do_fill, ev_valid;
  logic [LIM_W-1:0]     cfg_ext, limit;
  logic [RW-1:0]        last_rank, hit_rank;
  logic [IDX_W-1:0]     tgt_idx;
  logic [PAGE_BITS-1:0] ev_page;
  lrup_upd_t            upd;

  lrup_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .frames_in_use_o(frames_in_use)
  );

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign cfg_ext = LIM_W'(frames_in_use);
  assign limit   = (cfg_ext == '0) ? LIM_W'(1) :
                   ((cfg_ext > LIM_W'(FRAMES)) ? LIM_W'(FRAMES) : cfg_ext);

  assign last_rank = RW'(filled_q - CNT_W'(1));
  assign is_hit    = scan[FRAMES].hit_seen;
  assign do_fill   = !is_hit && (LIM_W'(filled_q) < limit);
  assign ev_valid  = !is_hit && !do_fill;

  assign upd.en   = accept;
  assign upd.hit  = is_hit;
  assign upd.fill = do_fill;

  assign scan[0] = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lrup_cell #(
      .FRAMES   (FRAMES),
      .PAGE_BITS(PAGE_BITS),
      .IDX      (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .scan_i     (scan[g]),
      .scan_o     (scan[g+1]),
      .page_i     (in_i.page_number),
      .last_rank_i(last_rank),
      .hit_rank_i (hit_rank),
      .filled_i   (filled_q),
      .upd_i      (upd),
      .hit_o      (hit_vec[g]),
      .sel_o      (sel_vec[g]),
      .rank_o     (rank_vec[g]),
      .page_o     (page_vec[g])
    );
  end

  always_comb begin
    hit_rank = '0;
    tgt_idx  = '0;
    ev_page  = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (hit_vec[i]) begin
        hit_rank = hit_rank | rank_vec[i];
      end
      if (sel_vec[i]) begin
        tgt_idx = tgt_idx | IDX_W'(i);
        ev_page = ev_page | page_vec[i];
      end
    end
  end

  always_comb begin
    filled_d = filled_q;
    fault_d  = fault_q;
    if (accept) begin
      if (do_fill) begin
        filled_d = filled_q + CNT_W'(1);
      end
      if (!is_hit && (fault_q != '1)) begin
        fault_d = fault_q + FAULT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q    <= '0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      filled_q <= filled_d;
      fault_q  <= fault_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_hit_q      <= is_hit;
      out_frame_q    <= FIDX_W'(tgt_idx);
      out_ev_valid_q <= ev_valid;
      out_ev_page_q  <= ev_valid ? ev_page : '0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.hit           = out_hit_q;
  assign out_o.frame_index   = out_frame_q;
  assign out_o.evicted_valid = out_ev_valid_q;
  assign out_o.evicted_page  = out_ev_page_q;
  assign out_o.fault_count   = fault_q;

endmodule

// ----- src/lrup_chk.sv -----
module lrup_chk
  import lrup_pkg::*;
#(
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_hit,
  input logic [FIDX_W-1:0]    out_frame_index,
  input logic                 out_evicted_valid,
  input logic [PAGE_BITS-1:0] out_evicted_page,
  input logic [FAULT_W-1:0]   out_fault_count
);

  // a hit never replaces a frame
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_hit |-> !out_evicted_valid)
    else $error("hit word reports an eviction");

  a_ev_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_evicted_valid |-> out_evicted_page == '0)
    else $error("evicted page nonzero without eviction");

  a_fault_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_hit |-> out_fault_count != '0)
    else $error("fault word with zero fault count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_index)
      && $stable(out_fault_count))
    else $error("stalled output word changed");

endmodule

bind lru_page_replacement lrup_chk #(
  .PAGE_BITS(PAGE_BITS)
) u_lrup_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid        (out_o.valid),
  .out_ready        (out_o.ready),
  .out_hit          (out_o.hit),
  .out_frame_index  (out_o.frame_index),
  .out_evicted_valid(out_o.evicted_valid),
  .out_evicted_page (out_o.evicted_page),
  .out_fault_count  (out_o.fault_count)
);
